[rtl/vls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vls_pkg: shared types and constants for the voxel line-of-sight block
// Field widths, memory word layout, stepper control group and request codes.
// ----------------------------------------------------------------------------
package vls_pkg;

  // request field widths
  localparam int A_W = 4;
  localparam int B_W = 7;
  localparam int C_W = 7;

  // stepper coordinate and error term widths
  localparam int CRD_W = 7;
  localparam int ERR_W = CRD_W + 3;

  // occupancy memory word layout
  localparam int WORD_W = 64;
  localparam int BIT_W  = $clog2(WORD_W);

  // default grid size
  localparam int SIZE_A_DEF = 16;
  localparam int SIZE_B_DEF = 128;
  localparam int SIZE_C_DEF = 128;

  // request codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // one voxel position
  typedef struct packed {
    logic [A_W-1:0] a;
    logic [B_W-1:0] b;
    logic [C_W-1:0] c;
  } pos_t;

  // stepper control group
  typedef struct packed {
    logic load;
    logic init;
    logic adv;
  } step_ctl_t;

endpackage
`default_nettype wire

[rtl/voxel_line_of_sight.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_line_of_sight: voxel occupancy store with 3d line-of-sight queries
// Write requests set one voxel bit; query requests walk a bresenham line.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | action, start_a/b/c, end_a/b/c, occupied
//  out_    | output    | out_valid/out_ready | visible, is_query
//
//  a query loads its result once the walk along the driving axis is done, or earlier
//  when a voxel on the line is blocked; with equal start and end there is nothing to
//  walk. one voxel per cycle goes through the stepper, an index stage and the
//  registered memory read.
//  a write goes through its steps in order: index, read, write back, result.
//  the next request is taken the cycle after the result is loaded.
//  after reset a clearing pass writes every memory word once (DEPTH words,
//  4096 with the default grid); no request is accepted meanwhile.
//  one request at a time; a held result stalls the next request at its result step.
// ----------------------------------------------------------------------------
module voxel_line_of_sight #(
  parameter int SIZE_A = vls_pkg::SIZE_A_DEF,
  parameter int SIZE_B = vls_pkg::SIZE_B_DEF,
  parameter int SIZE_C = vls_pkg::SIZE_C_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [vls_pkg::A_W-1:0] in_start_a,
  input  logic [vls_pkg::B_W-1:0] in_start_b,
  input  logic [vls_pkg::C_W-1:0] in_start_c,
  input  logic [vls_pkg::A_W-1:0] in_end_a,
  input  logic [vls_pkg::B_W-1:0] in_end_b,
  input  logic [vls_pkg::C_W-1:0] in_end_c,
  input  logic                    in_occupied,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_visible,
  output logic                    out_is_query
);
  import vls_pkg::*;

  localparam int VOXELS  = SIZE_A * SIZE_B * SIZE_C;
  localparam int IDX_RAW = $clog2(VOXELS);
  localparam int IDX_W   = (IDX_RAW > BIT_W) ? IDX_RAW : BIT_W + 1;
  localparam int WADDR_W = IDX_W - BIT_W;
  localparam int DEPTH   = (VOXELS + WORD_W - 1) / WORD_W;
  localparam logic [IDX_W-1:0]   PLANE   = IDX_W'(SIZE_B * SIZE_C);
  localparam logic [IDX_W-1:0]   ROW     = IDX_W'(SIZE_C);
  localparam logic [WADDR_W-1:0] CLR_END = WADDR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_INIT, S_WALK, S_WR_IDX, S_WR_RD, S_WR_WB, S_DONE
  } state_t;

  state_t             state_r;
  logic [WADDR_W-1:0] clr_r;
  logic               occ_r;
  logic               res_vis_r;
  logic               res_q_r;
  logic               out_valid_r;
  logic               out_visible_r;
  logic               out_is_query_r;

  logic               accept;
  step_ctl_t          stp_ctl;
  pos_t               start_pos;
  pos_t               end_pos;
  pos_t               pos;
  logic               stp_busy;

  logic [IDX_W-1:0]   idx_nxt;
  logic               grid_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic               grid2_r;
  logic [BIT_W-1:0]   bit3_r;
  logic               grid3_r;
  logic               s1_vld_r;
  logic               s2_vld_r;
  logic               s3_vld_r;
  logic               hit;
  logic               walk_empty;

  logic               mem_we;
  logic [WADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [WORD_W-1:0]  mem_rdata;
  logic [WORD_W-1:0]  merged;

  // request handshake
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign start_pos.a = in_start_a;
  assign start_pos.b = in_start_b;
  assign start_pos.c = in_start_c;
  assign end_pos.a   = in_end_a;
  assign end_pos.b   = in_end_b;
  assign end_pos.c   = in_end_c;

  // stepper control
  assign stp_ctl.load = accept;
  assign stp_ctl.init = (state_r == S_INIT);
  assign stp_ctl.adv  = (state_r == S_WALK) && stp_busy && !hit;

  vls_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stp_ctl),
    .start_pos (start_pos),
    .end_pos   (end_pos),
    .pos       (pos),
    .busy      (stp_busy)
  );

  // voxel index and grid check of the current position
  assign idx_nxt  = IDX_W'(pos.a) * PLANE + IDX_W'(pos.b) * ROW + IDX_W'(pos.c);
  assign grid_nxt = (32'(pos.a) < SIZE_A) && (32'(pos.b) < SIZE_B)
                    && (32'(pos.c) < SIZE_C);

  // index and read stages
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    grid2_r <= grid_nxt;
    if (mem_re) begin
      bit3_r  <= idx_r[BIT_W-1:0];
      grid3_r <= grid2_r;
    end
  end

  // stage valid flags of the walk pipeline
  always_ff @(posedge clk) begin
    if (!rst_n || accept) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= stp_ctl.adv;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  assign hit        = s3_vld_r && grid3_r && mem_rdata[bit3_r];
  assign walk_empty = !stp_busy && !s1_vld_r && !s2_vld_r && !s3_vld_r;

  // read-modify-write merge of one voxel bit
  always_comb begin
    merged         = mem_rdata;
    merged[bit3_r] = occ_r;
  end

  // memory port selection
  assign mem_re    = s2_vld_r || (state_r == S_WR_RD);
  assign mem_we    = (state_r == S_CLR) || ((state_r == S_WR_WB) && grid3_r);
  assign mem_waddr = (state_r == S_CLR) ? clr_r : idx_r[IDX_W-1:BIT_W];
  assign mem_wdata = (state_r == S_CLR) ? '0 : merged;

  vls_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (WADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (idx_r[IDX_W-1:BIT_W]),
    .rd_data (mem_rdata)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: load on a finished request, drop when taken
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLR_END) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            occ_r   <= in_occupied;
            state_r <= (in_action == ACT_QUERY) ? S_INIT : S_WR_IDX;
          end
        end
        S_INIT: begin
          state_r <= S_WALK;
        end
        S_WALK: begin
          priority if (hit) begin
            res_vis_r <= 1'b0;
            res_q_r   <= 1'b1;
            state_r   <= S_DONE;
          end else if (walk_empty) begin
            res_vis_r <= 1'b1;
            res_q_r   <= 1'b1;
            state_r   <= S_DONE;
          end else begin
            state_r   <= S_WALK;
          end
        end
        S_WR_IDX: begin
          state_r <= S_WR_RD;
        end
        S_WR_RD: begin
          state_r <= S_WR_WB;
        end
        S_WR_WB: begin
          res_vis_r <= 1'b0;
          res_q_r   <= 1'b0;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_visible_r  <= res_vis_r;
            out_is_query_r <= res_q_r;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = out_visible_r;
  assign out_is_query = out_is_query_r;

  // a blocked voxel ends the walk at once
  a_hit_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && hit |=> (state_r == S_DONE))
    else $error("walk continued after a blocked voxel");

  // memory never reads and writes in the same cycle
  a_mem_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re)
    else $error("memory read and write collide");

  // write acknowledges never report visible
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_query |-> !out_visible)
    else $error("write acknowledge reports visible");

  // no result appears during the clearing pass
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid_r && !in_ready)
    else $error("activity during clearing pass");

endmodule
`default_nettype wire

[rtl/vls_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vls_store: occupancy bit memory
// One write port and one read port, words of WORD_W voxels, registered read.
// ----------------------------------------------------------------------------
module vls_store #(
  parameter int DEPTH  = (vls_pkg::SIZE_A_DEF * vls_pkg::SIZE_B_DEF
                          * vls_pkg::SIZE_C_DEF) / vls_pkg::WORD_W,
  parameter int ADDR_W = 12
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [vls_pkg::WORD_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [vls_pkg::WORD_W-1:0]  rd_data
);
  import vls_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_q[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/vls_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vls_step: 3d bresenham stepping unit
// Holds the walk position and error terms, advances one voxel per adv pulse.
// ----------------------------------------------------------------------------
module vls_step (
  input  logic               clk,
  input  logic               rst_n,
  input  vls_pkg::step_ctl_t ctl,
  input  vls_pkg::pos_t      start_pos,
  input  vls_pkg::pos_t      end_pos,
  output vls_pkg::pos_t      pos,
  output logic               busy
);
  import vls_pkg::*;

  logic [CRD_W-1:0]        p_r   [3];
  logic [CRD_W-1:0]        dl_r  [3];
  logic signed [ERR_W-1:0] e_r   [3];
  logic [2:0]              dir_r;
  logic [2:0]              drv_r;
  logic [CRD_W-1:0]        dd_r;
  logic [CRD_W-1:0]        cnt_r;

  logic [CRD_W-1:0]        st_w  [3];
  logic [CRD_W-1:0]        en_w  [3];
  logic [2:0]              drv_w;
  logic [CRD_W-1:0]        dd_w;

  // widen request coordinates to the common width
  always_comb begin
    st_w[0] = CRD_W'(start_pos.a);
    st_w[1] = CRD_W'(start_pos.b);
    st_w[2] = CRD_W'(start_pos.c);
    en_w[0] = CRD_W'(end_pos.a);
    en_w[1] = CRD_W'(end_pos.b);
    en_w[2] = CRD_W'(end_pos.c);
  end

  // driving axis: largest span, ties a before b before c
  always_comb begin
    drv_w[0] = (dl_r[0] >= dl_r[1]) && (dl_r[0] >= dl_r[2]);
    drv_w[1] = !drv_w[0] && (dl_r[1] >= dl_r[2]);
    drv_w[2] = !drv_w[0] && !drv_w[1];
    priority if (drv_w[0]) begin
      dd_w = dl_r[0];
    end else if (drv_w[1]) begin
      dd_w = dl_r[1];
    end else begin
      dd_w = dl_r[2];
    end
  end

  // position, spans and error terms
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (ctl.load) begin
        p_r[k]   <= st_w[k];
        dl_r[k]  <= (en_w[k] > st_w[k]) ? (en_w[k] - st_w[k]) : (st_w[k] - en_w[k]);
        dir_r[k] <= !(st_w[k] < en_w[k]);
      end else if (ctl.init) begin
        e_r[k] <= $signed({2'b00, dl_r[k], 1'b0}) - $signed({3'b000, dd_w});
      end else if (ctl.adv) begin
        if (drv_r[k] || !e_r[k][ERR_W-1]) begin
          p_r[k] <= dir_r[k] ? (p_r[k] - 1'b1) : (p_r[k] + 1'b1);
        end
        if (!drv_r[k]) begin
          if (!e_r[k][ERR_W-1]) begin
            e_r[k] <= e_r[k] + $signed({2'b00, dl_r[k], 1'b0})
                      - $signed({2'b00, dd_r, 1'b0});
          end else begin
            e_r[k] <= e_r[k] + $signed({2'b00, dl_r[k], 1'b0});
          end
        end
      end
    end
    if (ctl.init) begin
      drv_r <= drv_w;
      dd_r  <= dd_w;
    end
  end

  // remaining step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.load) begin
      cnt_r <= '0;
    end else if (ctl.init) begin
      cnt_r <= dd_w;
    end else if (ctl.adv && (cnt_r != '0)) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy  = (cnt_r != '0);
  assign pos.a = p_r[0][A_W-1:0];
  assign pos.b = p_r[1][B_W-1:0];
  assign pos.c = p_r[2][C_W-1:0];

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: voxel line-of-sight block
// Sends write and query requests with random idling on both channels. A local
// voxel map and bresenham walk predict each answer; results are checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import vls_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 9;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int STALL_CYCLES   = 300;
  localparam int GRID_A         = SIZE_A_DEF;
  localparam int GRID_B         = SIZE_B_DEF;
  localparam int GRID_C         = SIZE_C_DEF;
  localparam int VOXELS         = GRID_A * GRID_B * GRID_C;

  typedef struct packed {
    logic visible;
    logic is_query;
  } answer_t;

  // block ports
  logic           clk          = 1'b0;
  logic           rst_n        = 1'b0;
  logic           in_valid     = 1'b0;
  logic           in_action    = ACT_WRITE;
  logic [A_W-1:0] in_start_a   = '0;
  logic [B_W-1:0] in_start_b   = '0;
  logic [C_W-1:0] in_start_c   = '0;
  logic [A_W-1:0] in_end_a     = '0;
  logic [B_W-1:0] in_end_b     = '0;
  logic [C_W-1:0] in_end_c     = '0;
  logic           in_occupied  = 1'b0;
  logic           out_ready    = 1'b0;
  logic           in_ready;
  logic           out_valid;
  logic           out_visible;
  logic           out_is_query;

  // local copy of the occupancy map and answers still owed by the block
  bit      voxel_occ [VOXELS];
  answer_t pending_answers [$];
  answer_t head_answer;
  int      err_count = 0;

  // idling control
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic stall_req     = 1'b0;
  int   stall_left    = 0;

  // region where writes and short queries cluster
  pos_t hot_lo;
  int   hot_ext_b;
  int   hot_ext_c;

  voxel_line_of_sight i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_start_a   (in_start_a),
    .in_start_b   (in_start_b),
    .in_start_c   (in_start_c),
    .in_end_a     (in_end_a),
    .in_end_b     (in_end_b),
    .in_end_c     (in_end_c),
    .in_occupied  (in_occupied),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_visible  (out_visible),
    .out_is_query (out_is_query)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side: random idling, or a long hold-off on request
  always @(posedge clk) begin
    if (stall_req) begin
      stall_left <= STALL_CYCLES;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result with the oldest owed answer
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual visible %0b is_query %0b",
                 $time, out_visible, out_is_query);
        err_count++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (out_visible !== head_answer.visible) begin
          $display("%0t: visible expected %0b actual %0b",
                   $time, head_answer.visible, out_visible);
          err_count++;
        end
        if (out_is_query !== head_answer.is_query) begin
          $display("%0t: is_query expected %0b actual %0b",
                   $time, head_answer.is_query, out_is_query);
          err_count++;
        end
      end
    end
  end

  function automatic int voxel_idx(int a, int b, int c);
    return (a * GRID_B + b) * GRID_C + c;
  endfunction

  // bresenham walk from st to en; start voxel is skipped, end voxel tested
  function automatic logic predict_sight(pos_t st, pos_t en);
    int p [3];
    int q [3];
    int s [3];
    int dl [3];
    int d, m1, m2, e1, e2, k, n;
    p[0] = st.a; p[1] = st.b; p[2] = st.c;
    q[0] = en.a; q[1] = en.b; q[2] = en.c;
    for (k = 0; k < 3; k++) begin
      dl[k] = (q[k] > p[k]) ? q[k] - p[k] : p[k] - q[k];
      s[k]  = (p[k] < q[k]) ? 1 : -1;
    end
    // driving axis: largest span, ties go a before b before c
    if (dl[0] >= dl[1] && dl[0] >= dl[2]) begin
      d = 0; m1 = 1; m2 = 2;
    end else if (dl[1] >= dl[0] && dl[1] >= dl[2]) begin
      d = 1; m1 = 0; m2 = 2;
    end else begin
      d = 2; m1 = 1; m2 = 0;
    end
    e1 = 2 * dl[m1] - dl[d];
    e2 = 2 * dl[m2] - dl[d];
    for (n = 0; n < dl[d]; n++) begin
      p[d] += s[d];
      if (e1 >= 0) begin
        p[m1] += s[m1];
        e1 -= 2 * dl[d];
      end
      if (e2 >= 0) begin
        p[m2] += s[m2];
        e2 -= 2 * dl[d];
      end
      e1 += 2 * dl[m1];
      e2 += 2 * dl[m2];
      if (voxel_occ[voxel_idx(p[0], p[1], p[2])]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic pos_t mk_pos(int a, int b, int c);
    pos_t p;
    p.a = A_W'(a);
    p.b = B_W'(b);
    p.c = C_W'(c);
    return p;
  endfunction

  function automatic pos_t rand_pos();
    logic [A_W+B_W+C_W-1:0] r;
    r = (A_W+B_W+C_W)'($urandom);
    return r;
  endfunction

  function automatic pos_t hot_pos();
    return mk_pos(hot_lo.a + $urandom_range(3), hot_lo.b + $urandom_range(hot_ext_b),
                  hot_lo.c + $urandom_range(hot_ext_c));
  endfunction

  task automatic pick_hot_box();
    hot_ext_b = (8 << $urandom_range(2)) - 1;
    hot_ext_c = (8 << $urandom_range(2)) - 1;
    hot_lo    = mk_pos($urandom_range(GRID_A - 4), $urandom_range(GRID_B - 1 - hot_ext_b),
                       $urandom_range(GRID_C - 1 - hot_ext_c));
  endtask

  // send one request, then record the answer it owes
  task automatic send_req(logic act, pos_t st, pos_t en, logic occ);
    answer_t ans;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_start_a  <= st.a;
    in_start_b  <= st.b;
    in_start_c  <= st.c;
    in_end_a    <= en.a;
    in_end_b    <= en.b;
    in_end_c    <= en.c;
    in_occupied <= occ;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (act == ACT_WRITE) begin
      voxel_occ[voxel_idx(st.a, st.b, st.c)] = occ;
      ans.visible  = 1'b0;
      ans.is_query = 1'b0;
    end else begin
      ans.visible  = predict_sight(st, en);
      ans.is_query = 1'b1;
    end
    pending_answers.insert(pending_answers.size(), ans);
  endtask

  // sender pauses until every owed answer has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // mostly clustered writes and short queries, some long lines and noise
  task automatic random_item();
    int   pick;
    pos_t st;
    pos_t en;
    pick = $urandom_range(99);
    st   = rand_pos();
    en   = rand_pos();
    if (pick < 40) begin
      send_req(ACT_WRITE, hot_pos(), en, ($urandom_range(99) < 70));
    end else if (pick < 80) begin
      st = hot_pos();
      if ($urandom_range(19) == 0) en = st;
      else en = hot_pos();
      send_req(ACT_QUERY, st, en, 1'($urandom_range(1)));
    end else if (pick < 90) begin
      send_req(ACT_QUERY, st, en, 1'($urandom_range(1)));
    end else begin
      send_req(ACT_WRITE, st, en, 1'($urandom_range(1)));
    end
  endtask

  // write acknowledge, equal ends, occupied start, field extremes, ignored fields
  task automatic test_special_cases();
    send_idle_pct = 19;
    recv_idle_pct = 54;
    send_req(ACT_QUERY, mk_pos(3, 40, 90), mk_pos(3, 40, 90), 1'b0);
    send_req(ACT_WRITE, mk_pos(15, 127, 127), mk_pos(0, 0, 0), 1'b1);
    send_req(ACT_WRITE, mk_pos(0, 0, 0), mk_pos(15, 127, 127), 1'b1);
    send_req(ACT_QUERY, mk_pos(0, 0, 0), mk_pos(15, 127, 127), 1'b0);
    send_req(ACT_QUERY, mk_pos(15, 127, 127), mk_pos(0, 0, 0), 1'b1);
    send_req(ACT_QUERY, mk_pos(0, 0, 0), mk_pos(1, 0, 0), 1'b1);
    send_req(ACT_QUERY, mk_pos(0, 0, 0), mk_pos(0, 0, 0), 1'b0);
    send_req(ACT_WRITE, mk_pos(0, 0, 0), mk_pos(7, 63, 64), 1'b0);
    send_req(ACT_QUERY, mk_pos(15, 127, 127), mk_pos(0, 0, 0), 1'b0);
    // equal spans on two or three axes
    send_req(ACT_WRITE, mk_pos(2, 2, 2), mk_pos(0, 0, 0), 1'b1);
    send_req(ACT_QUERY, mk_pos(0, 0, 0), mk_pos(4, 4, 4), 1'b0);
    send_req(ACT_QUERY, mk_pos(0, 0, 0), mk_pos(4, 4, 0), 1'b0);
    send_req(ACT_WRITE, mk_pos(5, 9, 9), mk_pos(0, 0, 0), 1'b1);
    send_req(ACT_QUERY, mk_pos(5, 0, 0), mk_pos(5, 18, 18), 1'b0);
    send_req(ACT_QUERY, mk_pos(6, 10, 20), mk_pos(0, 16, 14), 1'b0);
    wait_drain();
  endtask

  // longest lines along each axis, the b axis in both directions, and a diagonal
  task automatic test_full_span_lines();
    send_req(ACT_WRITE, mk_pos(1, 60, 5), mk_pos(0, 0, 0), 1'b1);
    send_req(ACT_QUERY, mk_pos(1, 0, 5), mk_pos(1, 127, 5), 1'b0);
    send_req(ACT_QUERY, mk_pos(1, 127, 4), mk_pos(1, 0, 4), 1'b0);
    send_req(ACT_WRITE, mk_pos(2, 5, 100), mk_pos(0, 0, 0), 1'b1);
    send_req(ACT_QUERY, mk_pos(2, 5, 0), mk_pos(2, 5, 127), 1'b0);
    send_req(ACT_QUERY, mk_pos(0, 3, 3), mk_pos(15, 3, 3), 1'b0);
    send_req(ACT_QUERY, mk_pos(9, 0, 127), mk_pos(0, 127, 0), 1'b0);
    wait_drain();
  endtask

  // long result hold-off while requests keep coming
  task automatic test_output_stall();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pick_hot_box();
    stall_req <= 1'b1;
    @(posedge clk);
    stall_req <= 1'b0;
    for (k = 0; k < 6; k++) send_req(ACT_WRITE, hot_pos(), rand_pos(), 1'($urandom_range(1)));
    for (k = 0; k < 6; k++) send_req(ACT_QUERY, hot_pos(), hot_pos(), 1'($urandom_range(1)));
    wait_drain();
  endtask

  task automatic test_random_traffic(int count, int send_pct, int recv_pct);
    int k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (k = 0; k < count; k++) begin
      if (k % 60 == 0) pick_hot_box();
      random_item();
    end
    wait_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_full_span_lines();
    test_random_traffic(360, 19, 54);
    test_random_traffic(360, 54, 19);
    test_random_traffic(360, 0, 0);
    test_output_stall();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
